@@ hw/rtl/contiguous_frame_allocator_macros.svh @@
// assertion macros for the contiguous frame allocator
// used by the top level only; no other dependencies
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, disabled in reset
`define CFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ hw/rtl/cfa_pkg.sv @@
// shared types and constants of the contiguous frame allocator
// used by cfa_ctrl, cfa_dp and the top level; no dependencies
package cfa_pkg;

    localparam int FRAME_W   = 20;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] FREE_RESET = 11'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE = 2'd2;

    typedef enum logic [1:0] {CMD_ALLOC, CMD_RELEASE, CMD_MARK, CMD_INIT} cmd_t;
    typedef enum logic [1:0] {
        STATUS_OK, STATUS_NO_SPACE, STATUS_RANGE, STATUS_NOT_HEAD
    } status_t;
    typedef enum logic [1:0] {FS_FREE, FS_INACC, FS_HEAD, FS_ALLOC} fstate_t;

    typedef enum logic [3:0] {
        S_WIPE, S_IDLE, S_DISPATCH, S_SCAN, S_FILL, S_REL_RD, S_REL_CHK,
        S_WALK, S_MARK, S_INIT, S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {PTR_HOLD, PTR_ZERO, PTR_INC, PTR_IDX, PTR_HIT} ptr_op_t;
    typedef enum logic [2:0] {
        WR_NONE, WR_FILL, WR_FREE, WR_INACC, WR_WIPE, WR_INIT
    } wr_op_t;
    typedef enum logic [1:0] {FREE_HOLD, FREE_INC, FREE_SUB, FREE_INIT} free_op_t;
    typedef enum logic [2:0] {
        RES_HOLD, RES_OK, RES_HIT, RES_NO_SPACE, RES_RANGE, RES_NOT_HEAD
    } res_op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        ptr_op_t  ptr_op;
        logic     rd_req;
        logic     scan;
        logic     run_clr;
        wr_op_t   wr_op;
        logic     rem_load;
        logic     rem_dec;
        free_op_t free_op;
        res_op_t  res_op;
        logic     out_load;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        cmd_t    cmd;
        logic    cnt_zero;
        logic    rel_ok;
        logic    mark_ok;
        logic    rvalid;
        fstate_t rdata;
        logic    hit;
        logic    scan_end;
        logic    rem_last;
        logic    wipe_last;
        logic    out_free;
    } sts_t;

endpackage

@@ hw/rtl/cfa_ctrl.sv @@
// controller state machine of the contiguous frame allocator
// depends on cfa_pkg; drives cfa_dp through ctl_t, reads sts_t
module cfa_ctrl
    import cfa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  sts_t   sts,
    output ctl_t   ctl
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WIPE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_WIPE: begin
                ctl.wr_op  = WR_WIPE;
                ctl.ptr_op = PTR_INC;
                if (sts.wipe_last) begin
                    ctl.ptr_op = PTR_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.cmd)
                    CMD_ALLOC: begin
                        if (sts.cnt_zero) begin
                            ctl.res_op = RES_NO_SPACE;
                            state_next = S_DONE;
                        end else begin
                            ctl.ptr_op  = PTR_ZERO;
                            ctl.run_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    CMD_RELEASE: begin
                        if (!sts.rel_ok) begin
                            ctl.res_op = RES_RANGE;
                            state_next = S_DONE;
                        end else begin
                            ctl.ptr_op = PTR_IDX;
                            state_next = S_REL_RD;
                        end
                    end
                    CMD_MARK: begin
                        if (!sts.mark_ok) begin
                            ctl.res_op = RES_RANGE;
                            state_next = S_DONE;
                        end else if (sts.cnt_zero) begin
                            ctl.res_op = RES_OK;
                            state_next = S_DONE;
                        end else begin
                            ctl.ptr_op   = PTR_IDX;
                            ctl.rem_load = 1'b1;
                            state_next   = S_MARK;
                        end
                    end
                    CMD_INIT: begin
                        ctl.ptr_op = PTR_ZERO;
                        state_next = S_INIT;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                ctl.rd_req = 1'b1;
                ctl.ptr_op = PTR_INC;
                ctl.scan   = 1'b1;
                if (sts.hit) begin
                    ctl.ptr_op   = PTR_HIT;
                    ctl.rem_load = 1'b1;
                    state_next   = S_FILL;
                end else if (sts.scan_end) begin
                    ctl.res_op = RES_NO_SPACE;
                    state_next = S_DONE;
                end
            end
            S_FILL: begin
                ctl.wr_op   = WR_FILL;
                ctl.ptr_op  = PTR_INC;
                ctl.rem_dec = 1'b1;
                if (sts.rem_last) begin
                    ctl.free_op = FREE_SUB;
                    ctl.res_op  = RES_HIT;
                    state_next  = S_DONE;
                end
            end
            S_REL_RD: begin
                ctl.rd_req = 1'b1;
                ctl.ptr_op = PTR_INC;
                state_next = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (sts.rdata != FS_HEAD) begin
                    ctl.res_op = RES_NOT_HEAD;
                    state_next = S_DONE;
                end else begin
                    ctl.wr_op   = WR_FREE;
                    ctl.free_op = FREE_INC;
                    ctl.rd_req  = 1'b1;
                    ctl.ptr_op  = PTR_INC;
                    state_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (sts.rvalid && sts.rdata == FS_ALLOC) begin
                    ctl.wr_op   = WR_FREE;
                    ctl.free_op = FREE_INC;
                    ctl.rd_req  = 1'b1;
                    ctl.ptr_op  = PTR_INC;
                end else begin
                    ctl.res_op = RES_OK;
                    state_next = S_DONE;
                end
            end
            S_MARK: begin
                ctl.wr_op   = WR_INACC;
                ctl.ptr_op  = PTR_INC;
                ctl.rem_dec = 1'b1;
                if (sts.rem_last) begin
                    ctl.free_op = FREE_SUB;
                    ctl.res_op  = RES_OK;
                    state_next  = S_DONE;
                end
            end
            S_INIT: begin
                ctl.wr_op  = WR_INIT;
                ctl.ptr_op = PTR_INC;
                if (sts.wipe_last) begin
                    ctl.ptr_op  = PTR_ZERO;
                    ctl.free_op = FREE_INIT;
                    ctl.res_op  = RES_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/cfa_dp.sv @@
// datapath of the contiguous frame allocator: frame state memory,
// pointers, counters, config registers and output register; uses cfa_pkg
module cfa_dp
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          s_tdata,   // frame_number[19:0], count[30:20], zero
    input  logic [1:0]           s_tuser,   // command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // result_frame[19:0], free_frames[30:20], zero
    output logic [1:0]           m_tuser,   // status[1:0]
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data,
    input  ctl_t                 ctl,
    output sts_t                 sts
);

    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int AW = $clog2(MAX_FRAMES);

    // config registers
    logic [FRAME_W-1:0] base_reg;
    logic [COUNT_W-1:0] pool_reg;
    logic               reserve_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            pool_reg    <= 11'd1024;
            reserve_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE:    base_reg    <= cfg_data;
                CFG_POOL:    pool_reg    <= cfg_data[COUNT_W-1:0];
                CFG_RESERVE: reserve_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // latched command word
    cmd_t               cmd_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [COUNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= cmd_t'(s_tuser);
            frame_reg <= s_tdata[FRAME_W-1:0];
            cnt_reg   <= s_tdata[FRAME_W+COUNT_W-1:FRAME_W];
        end
    end

    // pool size and range checks
    logic [NW-1:0]      n_pool;
    logic [FRAME_W:0]   diff;
    logic [NW-1:0]      idx;

    assign n_pool = (32'(pool_reg) < 32'(MAX_FRAMES)) ? NW'(pool_reg) : NW'(MAX_FRAMES);
    assign diff   = {1'b0, frame_reg} - {1'b0, base_reg};
    assign idx    = diff[NW-1:0];

    // pointers, run length, head and remaining count
    logic [NW-1:0]      ptr_reg, ptr_next;
    logic [NW-1:0]      rptr_reg;
    logic               rvalid_reg;
    logic [COUNT_W-1:0] run_reg;
    logic [NW-1:0]      head_reg, head_next;
    logic [COUNT_W-1:0] rem_reg;
    fstate_t            rdata_reg;
    logic               hit;

    assign head_next = NW'(32'(rptr_reg) + 32'd1 - 32'(cnt_reg));
    assign hit = rvalid_reg && (rdata_reg == FS_FREE) && (run_reg + 11'd1 == cnt_reg);

    always_comb begin
        unique case (ctl.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + 1'b1;
            PTR_IDX:  ptr_next = idx;
            PTR_HIT:  ptr_next = head_next;
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            ptr_reg    <= ptr_next;
            rvalid_reg <= ctl.rd_req && (ptr_reg < n_pool);
        end
    end

    always_ff @(posedge aclk) begin
        rptr_reg <= ptr_reg;
        if (ctl.run_clr) begin
            run_reg <= '0;
        end else if (ctl.scan && rvalid_reg) begin
            run_reg <= (rdata_reg == FS_FREE) ? run_reg + 11'd1 : '0;
        end
        if (ctl.scan && hit) begin
            head_reg <= head_next;
        end
        if (ctl.rem_load) begin
            rem_reg <= cnt_reg;
        end else if (ctl.rem_dec) begin
            rem_reg <= rem_reg - 11'd1;
        end
    end

    // frame state memory, one write and one registered read a cycle
    fstate_t        mem [MAX_FRAMES];
    logic           we;
    logic [AW-1:0]  waddr;
    fstate_t        wdata;

    always_comb begin
        we    = 1'b1;
        waddr = ptr_reg[AW-1:0];
        wdata = FS_FREE;
        unique case (ctl.wr_op)
            WR_NONE:  we = 1'b0;
            WR_FILL:  wdata = (ptr_reg == head_reg) ? FS_HEAD : FS_ALLOC;
            WR_FREE:  waddr = rptr_reg[AW-1:0];
            WR_INACC: wdata = FS_INACC;
            WR_WIPE:  wdata = (ptr_reg == '0) ? FS_HEAD : FS_FREE;
            WR_INIT:  wdata = (ptr_reg == '0 && reserve_reg && n_pool != '0)
                              ? FS_HEAD : FS_FREE;
            default:  we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[ptr_reg[AW-1:0]];
    end

    // running free count
    logic [COUNT_W-1:0] free_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= FREE_RESET;
        end else begin
            unique case (ctl.free_op)
                FREE_HOLD: ;
                FREE_INC:  if (free_reg != COUNT_MAX) free_reg <= free_reg + 11'd1;
                FREE_SUB:  free_reg <= (cnt_reg >= free_reg) ? '0 : free_reg - cnt_reg;
                FREE_INIT: free_reg <= (reserve_reg && n_pool != '0)
                                       ? COUNT_W'(n_pool - 1'b1) : COUNT_W'(n_pool);
                default:   ;
            endcase
        end
    end

    // pending result
    logic [FRAME_W-1:0] res_frame_reg;
    status_t            res_status_reg;

    always_ff @(posedge aclk) begin
        unique case (ctl.res_op)
            RES_HOLD: ;
            RES_OK: begin
                res_frame_reg  <= '0;
                res_status_reg <= STATUS_OK;
            end
            RES_HIT: begin
                res_frame_reg  <= FRAME_W'(32'(base_reg) + 32'(head_reg));
                res_status_reg <= STATUS_OK;
            end
            RES_NO_SPACE: begin
                res_frame_reg  <= '0;
                res_status_reg <= STATUS_NO_SPACE;
            end
            RES_RANGE: begin
                res_frame_reg  <= '0;
                res_status_reg <= STATUS_RANGE;
            end
            RES_NOT_HEAD: begin
                res_frame_reg  <= '0;
                res_status_reg <= STATUS_NOT_HEAD;
            end
            default: ;
        endcase
    end

    // output register
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic [1:0]         m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_data_reg <= {1'b0, free_reg, res_frame_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // status to controller
    assign sts.cmd       = cmd_reg;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.rel_ok    = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(n_pool));
    assign sts.mark_ok   = !diff[FRAME_W] &&
                           ((22'(base_reg) + 22'(n_pool)) >= (22'(frame_reg) + 22'(cnt_reg)));
    assign sts.rvalid    = rvalid_reg;
    assign sts.rdata     = rdata_reg;
    assign sts.hit       = hit;
    assign sts.scan_end  = !rvalid_reg && (ptr_reg >= n_pool);
    assign sts.rem_last  = (rem_reg == 11'd1);
    assign sts.wipe_last = (ptr_reg == NW'(MAX_FRAMES - 1));
    assign sts.out_free  = !m_valid_reg || m_tready;

endmodule

@@ hw/rtl/contiguous_frame_allocator.sv @@
// commands are handled one at a time; each walk of the state memory covers one frame a cycle
// reset: synchronous, active low; afterwards a clearing pass over all MAX_FRAMES entries
// writes the state memory while s_tready stays low; config writes are taken meanwhile
module contiguous_frame_allocator
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // frame_number[19:0], count[30:20], zero
    input  logic [1:0]           s_tuser,   // command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // result_frame[19:0], free_frames[30:20], zero
    output logic [1:0]           m_tuser,   // status[1:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data
);

`include "contiguous_frame_allocator_macros.svh"

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    cfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    cfa_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts)
    );

    // one command in flight at a time
    `CFA_ASSERT_NEXT(a_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // no memory write while waiting for a command
    `CFA_ASSERT_NOW(a_idle_no_write, aclk, aresetn, s_tready, ctl.wr_op == WR_NONE)
    // failed commands report frame zero
    `CFA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK, m_tdata[19:0] == 20'd0)

endmodule

@@ dv/tb_contiguous_frame_allocator.sv @@
// self-checking testbench for the contiguous frame allocator
// depends on cfa_pkg and contiguous_frame_allocator only
`timescale 1ns / 100ps

module tb_contiguous_frame_allocator
    import cfa_pkg::*;
();

    localparam int POOL_MAX = 1024;

    typedef struct packed {
        cmd_t             cmd;
        logic [19:0]      frame;
        logic [10:0]      cnt;
    } cmd_word_t;

    typedef struct packed {
        logic [19:0] frame;
        status_t     status;
        logic [10:0] free;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FRAME_W-1:0] cfg_data = '0;

    contiguous_frame_allocator #(.MAX_FRAMES(POOL_MAX)) uut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow allocator state
    fstate_t     shadow_map [POOL_MAX];
    logic [10:0] shadow_free;
    logic [19:0] shadow_base;
    logic [10:0] shadow_pool;
    logic        shadow_reserve;

    cmd_word_t pending_cmds [$];
    answer_t   expected_answers [$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;
    logic      s_tready_seen = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pool_len();
        return (shadow_pool < POOL_MAX) ? int'(shadow_pool) : POOL_MAX;
    endfunction

    function automatic void free_sub(input int n);
        shadow_free = (n >= shadow_free) ? 11'd0 : shadow_free - 11'(n);
    endfunction

    function automatic void free_inc();
        if (shadow_free < COUNT_MAX) shadow_free++;
    endfunction

    function automatic void shadow_init();
        int n;
        n = pool_len();
        foreach (shadow_map[i]) shadow_map[i] = FS_FREE;
        shadow_free = 11'(n);
        if (shadow_reserve && n > 0) begin
            shadow_map[0] = FS_HEAD;
            shadow_free = 11'(n - 1);
        end
    endfunction

    // work out the answer for one command and update the shadow state
    function automatic answer_t predict_allocator(input cmd_word_t c);
        answer_t a;
        int n, run, head, idx, i;
        bit found;
        n = pool_len();
        a.frame = '0;
        a.status = STATUS_OK;
        found = 0;
        head = 0;
        run = 0;
        case (c.cmd)
            CMD_ALLOC: begin
                if (c.cnt > 0) begin
                    for (i = 0; i < n; i++) begin
                        run = (shadow_map[i] == FS_FREE) ? run + 1 : 0;
                        if (run == c.cnt) begin
                            head = i + 1 - int'(c.cnt);
                            found = 1;
                            break;
                        end
                    end
                end
                if (found) begin
                    shadow_map[head] = FS_HEAD;
                    for (i = head + 1; i < head + int'(c.cnt); i++) shadow_map[i] = FS_ALLOC;
                    free_sub(int'(c.cnt));
                    a.frame = shadow_base + 20'(head);
                end else begin
                    a.status = STATUS_NO_SPACE;
                end
            end
            CMD_RELEASE: begin
                if (c.frame < shadow_base || int'(c.frame - shadow_base) >= n) begin
                    a.status = STATUS_RANGE;
                end else begin
                    idx = int'(c.frame - shadow_base);
                    if (shadow_map[idx] != FS_HEAD) begin
                        a.status = STATUS_NOT_HEAD;
                    end else begin
                        shadow_map[idx] = FS_FREE;
                        free_inc();
                        for (i = idx + 1; i < n && shadow_map[i] == FS_ALLOC; i++) begin
                            shadow_map[i] = FS_FREE;
                            free_inc();
                        end
                    end
                end
            end
            CMD_MARK: begin
                if (c.frame < shadow_base
                        || longint'(shadow_base) + n < longint'(c.frame) + c.cnt) begin
                    a.status = STATUS_RANGE;
                end else begin
                    idx = int'(c.frame - shadow_base);
                    for (i = idx; i < idx + int'(c.cnt) && i < n; i++) shadow_map[i] = FS_INACC;
                    free_sub(int'(c.cnt));
                end
            end
            default: shadow_init();
        endcase
        a.free = shadow_free;
        return a;
    endfunction

    // driver: offers queued commands and sets m_tready at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_cmds[0].cmd;
                    s_tdata <= {1'b0, pending_cmds[0].cnt, pending_cmds[0].frame};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= (hold_off == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // accepted input word: predict and pop
    always @(posedge aclk) begin
        s_tready_seen <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_answers.push_back(predict_allocator(pending_cmds.pop_front()));
        end
    end

    // receiver hold-off countdown
    always @(posedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_answers.pop_front();
                if (m_tdata[19:0] !== want.frame)
                    report_mismatch("result_frame", int'(m_tdata[19:0]), int'(want.frame));
                if (m_tuser !== want.status)
                    report_mismatch("status", int'(m_tuser), int'(want.status));
                if (m_tdata[30:20] !== want.free)
                    report_mismatch("free_frames", int'(m_tdata[30:20]), int'(want.free));
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("pad bit", int'(m_tdata[31]), 0);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BASE:    shadow_base = val;
            CFG_POOL:    shadow_pool = val[10:0];
            CFG_RESERVE: shadow_reserve = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(input cmd_t c, input logic [19:0] f, input logic [10:0] n);
        cmd_word_t w;
        w.cmd = c;
        w.frame = f;
        w.cnt = n;
        pending_cmds.push_back(w);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_answers.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // random traffic, mostly alloc and release, with mark and init mixed in, over the current pool
    task automatic random_cmds(input int num);
        int n, pick;
        n = pool_len();
        repeat (num) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                push_cmd(CMD_ALLOC, 20'($urandom), ($urandom_range(3) == 0)
                    ? 11'($urandom_range(2047)) : 11'($urandom_range(12)));
            end else if (pick < 70) begin
                push_cmd(CMD_RELEASE, shadow_base + 20'($urandom_range(n)), 11'($urandom));
            end else if (pick < 85) begin
                push_cmd(CMD_MARK, shadow_base + 20'($urandom_range(n)),
                    11'($urandom_range(6)));
            end else if (pick < 95) begin
                push_cmd(cmd_t'($urandom_range(2)), 20'($urandom), 11'($urandom));
            end else begin
                push_cmd(CMD_INIT, 20'($urandom), 11'($urandom));
            end
        end
    endtask

    // stimulus
    initial begin
        shadow_base = '0;
        shadow_pool = 11'd1024;
        shadow_reserve = 1'b1;
        foreach (shadow_map[i]) shadow_map[i] = FS_FREE;
        shadow_map[0] = FS_HEAD;
        shadow_free = FREE_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: default pool
        push_cmd(CMD_ALLOC, 20'd0, 11'd0);
        push_cmd(CMD_ALLOC, 20'hFFFFF, 11'd1);
        push_cmd(CMD_ALLOC, 20'd0, 11'd5);
        push_cmd(CMD_RELEASE, 20'd2, 11'd0);
        push_cmd(CMD_RELEASE, 20'd1, 11'd0);
        push_cmd(CMD_RELEASE, 20'd1024, 11'd0);
        push_cmd(CMD_RELEASE, 20'hFFFFF, 11'h7FF);
        push_cmd(CMD_MARK, 20'd1000, 11'd24);
        push_cmd(CMD_MARK, 20'd1000, 11'd25);
        push_cmd(CMD_MARK, 20'd3, 11'd0);
        push_cmd(CMD_MARK, 20'd2, 11'd2);
        push_cmd(CMD_ALLOC, 20'd0, 11'd1024);
        push_cmd(CMD_ALLOC, 20'd0, 11'd2047);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        push_cmd(CMD_ALLOC, 20'd0, 11'd1023);
        push_cmd(CMD_RELEASE, 20'd1, 11'd0);
        push_cmd(CMD_MARK, 20'd0, 11'd1024);
        push_cmd(CMD_MARK, 20'd0, 11'd1024);
        push_cmd(CMD_RELEASE, 20'd0, 11'd0);
        drain();

        // small pool with high base, no reserve
        write_reg(CFG_BASE, 20'hFFFF0);
        write_reg(CFG_POOL, 20'd8);
        write_reg(CFG_RESERVE, 20'd0);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        push_cmd(CMD_ALLOC, 20'd0, 11'd8);
        push_cmd(CMD_RELEASE, 20'hFFFF0, 11'd0);
        push_cmd(CMD_MARK, 20'hFFFEF, 11'd1);
        push_cmd(CMD_MARK, 20'hFFFF7, 11'd1);
        drain();
        random_cmds(90);
        drain();

        // pressure: receiver holds off while the sender keeps going
        hold_off = 400;
        random_cmds(20);
        drain();

        // zero pool and odd pool, then pool beyond the maximum
        write_reg(CFG_POOL, 20'd0);
        write_reg(CFG_BASE, 20'd100);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        push_cmd(CMD_ALLOC, 20'd0, 11'd1);
        push_cmd(CMD_MARK, 20'd100, 11'd0);
        push_cmd(CMD_RELEASE, 20'd100, 11'd0);
        drain();
        write_reg(CFG_POOL, 20'd13);
        write_reg(CFG_RESERVE, 20'd1);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        drain();
        send_idle_pct = 74;
        random_cmds(100);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 74;
        write_reg(CFG_POOL, 20'd2047);
        write_reg(CFG_BASE, 20'd0);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        random_cmds(60);
        drain();

        send_idle_pct = 6;
        recv_stall_pct = 6;
        write_reg(CFG_POOL, 20'd40);
        write_reg(CFG_BASE, 20'h12345);
        push_cmd(CMD_INIT, 20'd0, 11'd0);
        random_cmds(160);
        drain();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/cfa_dp.sv
hw/rtl/contiguous_frame_allocator.sv
dv/tb_contiguous_frame_allocator.sv
